// ----- hdl/mwsk_pkg.sv -----
`timescale 1ns / 1ps

package mwsk_pkg;

	// lane count and datapath widths
	localparam int LANES  = 4;
	localparam int SCL_W  = 27;             // 2000 * lin
	localparam int NW     = 30;             // signed wheel numerator
	localparam int MAGA_W = NW - 1;         // |numerator|
	localparam int NUMA_W = MAGA_W + 8;     // 256 * |numerator| + rounding
	localparam int DEN_W  = 19;             // 125 * radius
	localparam int QA_W   = 30;             // unsaturated speed magnitude
	localparam int SPD_W  = 24;
	localparam int MAX_W  = 23;
	localparam int BIG_W  = QA_W;
	localparam int NUMB_W = BIG_W + MAX_W;  // |speed| * ceiling + rounding
	localparam int QB_W   = MAX_W;          // scaled magnitude never exceeds the ceiling

	// constants of the fixed-point kinematics
	localparam logic signed [SCL_W-1:0] LIN_SCALE = SCL_W'(2000);
	localparam logic [DEN_W-1:0] DEN_SCALE = DEN_W'(125);
	localparam logic [QA_W-1:0] POS_LIM = QA_W'(8388607);
	localparam logic [QA_W-1:0] NEG_LIM = QA_W'(8388608);
	localparam logic [SPD_W-1:0] SPD_MAX = 24'h7FFFFF;
	localparam logic [SPD_W-1:0] SPD_MIN = 24'h800000;

	// lane order: front left, front right, rear left, rear right (bit i = lane i)
	localparam logic [LANES-1:0] Y_NEG = 4'b1001;
	localparam logic [LANES-1:0] W_NEG = 4'b0101;

	typedef enum logic [2:0] {
		CFG_SEP_X,
		CFG_SEP_Y,
		CFG_RAD_FL,
		CFG_RAD_FR,
		CFG_RAD_RL,
		CFG_RAD_RR,
		CFG_MAX_SPEED,
		CFG_TIMEOUT
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] lin_x;
		logic signed [15:0] lin_y;
		logic signed [15:0] ang_z;
		logic [15:0]        command_age_ms;
	} cmd_t;

	typedef struct packed {
		logic signed [SPD_W-1:0] speed_front_left;
		logic signed [SPD_W-1:0] speed_front_right;
		logic signed [SPD_W-1:0] speed_rear_left;
		logic signed [SPD_W-1:0] speed_rear_right;
		logic                    timed_out;
		logic                    scaled_down;
	} wheel_t;

endpackage

// ----- hdl/mecanum_wheel_speed_kinematics_core.sv -----
`timescale 1ns / 1ps

// Mecanum inverse kinematics: body velocity command in, four wheel speeds out.
// Input channel in_valid/in_stall/in_data carries one command beat (lin_x,
// lin_y, ang_z, command_age_ms); output channel out_valid/out_stall/out_data
// carries one result beat (four speeds in 1/256 rad/s, timed_out, scaled_down).
// The user must write registers through cfg_wr/cfg_addr/cfg_data only while the
// block is idle, which the block itself does not enforce; they take effect for
// every later command. The two pipelined restoring dividers produce one quotient
// bit per stage (30 stages for the wheel division, 23 for the ceiling scaling).
// Throughput: one beat per cycle while the output is not stalled.
// Stall: the whole pipeline holds while the output register is full and
// out_stall is high; in_stall is raised in exactly those cycles, so no beat
// is lost or repeated. Bubbles are not squeezed out during a stall.
// Reset (arst_n low): all valid bits clear, registers return to their
// defaults (separations 0, radii 800, ceiling 0, timeout 500).
module mecanum_wheel_speed_kinematics_core import mwsk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cmd_t              in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output wheel_t            out_data,
	input  logic              cfg_wr,
	input  logic [2:0]        cfg_addr,
	input  logic [MAX_W-1:0]  cfg_data
);

	logic adv;
	logic out_valid_q;
	wheel_t out_data_q;

	// global pipeline advance
	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// configuration registers
	logic [11:0] sep_x_q, sep_y_q;
	logic [11:0] rad_fl_q, rad_fr_q, rad_rl_q, rad_rr_q;
	logic [MAX_W-1:0] max_q;
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_x_q   <= '0;
			sep_y_q   <= '0;
			rad_fl_q  <= 12'd800;
			rad_fr_q  <= 12'd800;
			rad_rl_q  <= 12'd800;
			rad_rr_q  <= 12'd800;
			max_q     <= '0;
			timeout_q <= 16'd500;
		end else if (cfg_wr) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_SEP_X:     sep_x_q   <= cfg_data[11:0];
				CFG_SEP_Y:     sep_y_q   <= cfg_data[11:0];
				CFG_RAD_FL:    rad_fl_q  <= cfg_data[11:0];
				CFG_RAD_FR:    rad_fr_q  <= cfg_data[11:0];
				CFG_RAD_RL:    rad_rl_q  <= cfg_data[11:0];
				CFG_RAD_RR:    rad_rr_q  <= cfg_data[11:0];
				CFG_MAX_SPEED: max_q     <= cfg_data;
				CFG_TIMEOUT:   timeout_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// divisors from config, zero radius counts as one
	logic [12:0] sep_sum;
	logic [11:0] rad [LANES];
	logic [DEN_W-1:0] den [LANES];

	assign sep_sum = {1'b0, sep_x_q} + {1'b0, sep_y_q};

	always_comb begin
		rad[0] = rad_fl_q;
		rad[1] = rad_fr_q;
		rad[2] = rad_rl_q;
		rad[3] = rad_rr_q;
		for (int l = 0; l < LANES; l++) begin
			den[l] = DEN_SCALE * DEN_W'((rad[l] == 12'd0) ? 12'd1 : rad[l]);
		end
	end

	// ---------------------------------------------------------------
	// stage 1: timeout and scaled command terms
	logic vld_s1, to_s1;
	logic signed [SCL_W-1:0] xs_s1, ys_s1;
	logic signed [NW-1:0] ws_s1;
	logic tout;

	assign tout = in_data.command_age_ms > timeout_q;

	// stage 2: per-wheel numerator
	logic vld_s2, to_s2;
	logic signed [NW-1:0] n_s2 [LANES];
	logic signed [NW-1:0] n_nx [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			n_nx[l] = NW'(xs_s1)
				+ (Y_NEG[l] ? -NW'(ys_s1) : NW'(ys_s1))
				+ (W_NEG[l] ? -ws_s1 : ws_s1);
		end
	end

	// ---------------------------------------------------------------
	// divider A: 256*|n| / (125*r), stage 0 loads numerator with rounding
	logic [QA_W:0] diva_vld_s, diva_to_s;
	logic [LANES-1:0] diva_neg_s [0:QA_W];
	logic [NUMA_W-1:0] diva_num_s [0:QA_W][LANES];
	logic [DEN_W-1:0] diva_rem_s [0:QA_W][LANES];
	logic [QA_W-1:0] diva_q_s [0:QA_W][LANES];
	logic [DEN_W-1:0] diva_rem_nx [1:QA_W][LANES];
	logic [QA_W-1:0] diva_q_nx [1:QA_W][LANES];
	logic [NUMA_W-1:0] a0_num [LANES];
	logic [LANES-1:0] a0_neg;

	// load: sign, magnitude, half-divisor bias
	always_comb begin : diva_load
		logic [MAGA_W-1:0] m;
		for (int l = 0; l < LANES; l++) begin
			a0_neg[l] = n_s2[l][NW-1];
			m = a0_neg[l] ? MAGA_W'(-n_s2[l]) : MAGA_W'(n_s2[l]);
			a0_num[l] = {m, 8'd0} + NUMA_W'(den[l] >> 1);
		end
	end

	// one quotient bit per stage
	always_comb begin : diva_step
		logic [DEN_W:0] t;
		for (int k = 0; k < QA_W; k++) begin
			for (int l = 0; l < LANES; l++) begin
				t = {diva_rem_s[k][l], diva_num_s[k][l][QA_W-1-k]};
				if (t >= {1'b0, den[l]}) begin
					diva_rem_nx[k+1][l] = DEN_W'(t - {1'b0, den[l]});
					diva_q_nx[k+1][l] = {diva_q_s[k][l][QA_W-2:0], 1'b1};
				end else begin
					diva_rem_nx[k+1][l] = DEN_W'(t);
					diva_q_nx[k+1][l] = {diva_q_s[k][l][QA_W-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 4: sign and saturate, keep unsaturated magnitude
	logic vld_s4, to_s4;
	logic [LANES-1:0] neg_s4;
	logic [QA_W-1:0] mag_s4 [LANES];
	logic [SPD_W-1:0] sat_s4 [LANES];
	logic [SPD_W-1:0] sat_nx [LANES];

	always_comb begin : sat_calc
		logic [QA_W-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			q = diva_q_s[QA_W][l];
			if (!diva_neg_s[QA_W][l]) begin
				sat_nx[l] = (q > POS_LIM) ? SPD_MAX : SPD_W'(q);
			end else begin
				sat_nx[l] = (q > NEG_LIM) ? SPD_MIN : SPD_W'(-q);
			end
		end
	end

	// stage 5: largest magnitude and ceiling check
	logic vld_s5, to_s5, scl_s5;
	logic [LANES-1:0] neg_s5;
	logic [QA_W-1:0] mag_s5 [LANES];
	logic [SPD_W-1:0] sat_s5 [LANES];
	logic [BIG_W-1:0] big_s5;
	logic [BIG_W-1:0] m01, m23, big_nx;

	assign m01 = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
	assign m23 = (mag_s4[2] > mag_s4[3]) ? mag_s4[2] : mag_s4[3];
	assign big_nx = (m01 > m23) ? m01 : m23;

	// stage 6: magnitude times ceiling
	logic vld_s6, to_s6, scl_s6;
	logic [LANES-1:0] neg_s6;
	logic [SPD_W-1:0] sat_s6 [LANES];
	logic [BIG_W-1:0] big_s6;
	logic [NUMB_W-1:0] prod_s6 [LANES];

	// ---------------------------------------------------------------
	// divider B: (|s|*max + big/2) / big
	logic [QB_W:0] divb_vld_s, divb_to_s, divb_scl_s;
	logic [LANES-1:0] divb_neg_s [0:QB_W];
	logic [SPD_W-1:0] divb_sat_s [0:QB_W][LANES];
	logic [BIG_W-1:0] divb_big_s [0:QB_W];
	logic [NUMB_W-1:0] divb_num_s [0:QB_W][LANES];
	logic [BIG_W-1:0] divb_rem_s [0:QB_W][LANES];
	logic [QB_W-1:0] divb_q_s [0:QB_W][LANES];
	logic [BIG_W-1:0] divb_rem_nx [1:QB_W][LANES];
	logic [QB_W-1:0] divb_q_nx [1:QB_W][LANES];
	logic [NUMB_W-1:0] b0_num [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			b0_num[l] = prod_s6[l] + NUMB_W'(big_s6 >> 1);
		end
	end

	always_comb begin : divb_step
		logic [BIG_W:0] t;
		for (int k = 0; k < QB_W; k++) begin
			for (int l = 0; l < LANES; l++) begin
				t = {divb_rem_s[k][l], divb_num_s[k][l][QB_W-1-k]};
				if (t >= {1'b0, divb_big_s[k]}) begin
					divb_rem_nx[k+1][l] = BIG_W'(t - {1'b0, divb_big_s[k]});
					divb_q_nx[k+1][l] = {divb_q_s[k][l][QB_W-2:0], 1'b1};
				end else begin
					divb_rem_nx[k+1][l] = BIG_W'(t);
					divb_q_nx[k+1][l] = {divb_q_s[k][l][QB_W-2:0], 1'b0};
				end
			end
		end
	end

	// output select: scaled quotient or saturated speed
	logic [SPD_W-1:0] spd_nx [LANES];
	wheel_t out_nx;

	always_comb begin : out_sel
		logic [SPD_W-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			q = SPD_W'(divb_q_s[QB_W][l]);
			if (divb_scl_s[QB_W]) begin
				spd_nx[l] = divb_neg_s[QB_W][l] ? -q : q;
			end else begin
				spd_nx[l] = divb_sat_s[QB_W][l];
			end
		end
		out_nx.speed_front_left  = spd_nx[0];
		out_nx.speed_front_right = spd_nx[1];
		out_nx.speed_rear_left   = spd_nx[2];
		out_nx.speed_rear_right  = spd_nx[3];
		out_nx.timed_out         = divb_to_s[QB_W];
		out_nx.scaled_down       = divb_scl_s[QB_W];
	end

	// ---------------------------------------------------------------
	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			diva_vld_s  <= '0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			divb_vld_s  <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			diva_vld_s  <= {diva_vld_s[QA_W-1:0], vld_s2};
			vld_s4      <= diva_vld_s[QA_W];
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			divb_vld_s  <= {divb_vld_s[QB_W-1:0], vld_s6};
			out_valid_q <= divb_vld_s[QB_W];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			to_s1 <= tout;
			xs_s1 <= tout ? '0 : SCL_W'(in_data.lin_x) * LIN_SCALE;
			ys_s1 <= tout ? '0 : SCL_W'(in_data.lin_y) * LIN_SCALE;
			ws_s1 <= tout ? '0 : $signed({17'd0, sep_sum}) * NW'(in_data.ang_z);
			// stage 2
			to_s2 <= to_s1;
			for (int l = 0; l < LANES; l++) begin
				n_s2[l] <= n_nx[l];
			end
			// divider A
			diva_to_s <= {diva_to_s[QA_W-1:0], to_s2};
			diva_neg_s[0] <= a0_neg;
			for (int l = 0; l < LANES; l++) begin
				diva_num_s[0][l] <= a0_num[l];
				diva_rem_s[0][l] <= DEN_W'(a0_num[l][NUMA_W-1:QA_W]);
				diva_q_s[0][l]   <= '0;
			end
			for (int k = 0; k < QA_W; k++) begin
				diva_neg_s[k+1] <= diva_neg_s[k];
				for (int l = 0; l < LANES; l++) begin
					diva_num_s[k+1][l] <= diva_num_s[k][l];
					diva_rem_s[k+1][l] <= diva_rem_nx[k+1][l];
					diva_q_s[k+1][l]   <= diva_q_nx[k+1][l];
				end
			end
			// stage 4
			to_s4  <= diva_to_s[QA_W];
			neg_s4 <= diva_neg_s[QA_W];
			for (int l = 0; l < LANES; l++) begin
				mag_s4[l] <= diva_q_s[QA_W][l];
				sat_s4[l] <= sat_nx[l];
			end
			// stage 5
			to_s5  <= to_s4;
			neg_s5 <= neg_s4;
			big_s5 <= big_nx;
			scl_s5 <= (max_q != '0) && (big_nx > BIG_W'(max_q));
			for (int l = 0; l < LANES; l++) begin
				mag_s5[l] <= mag_s4[l];
				sat_s5[l] <= sat_s4[l];
			end
			// stage 6
			to_s6  <= to_s5;
			neg_s6 <= neg_s5;
			scl_s6 <= scl_s5;
			big_s6 <= big_s5;
			for (int l = 0; l < LANES; l++) begin
				sat_s6[l]  <= sat_s5[l];
				prod_s6[l] <= NUMB_W'(mag_s5[l]) * NUMB_W'(max_q);
			end
			// divider B
			divb_to_s  <= {divb_to_s[QB_W-1:0], to_s6};
			divb_scl_s <= {divb_scl_s[QB_W-1:0], scl_s6};
			divb_neg_s[0] <= neg_s6;
			divb_big_s[0] <= big_s6;
			for (int l = 0; l < LANES; l++) begin
				divb_sat_s[0][l] <= sat_s6[l];
				divb_num_s[0][l] <= b0_num[l];
				divb_rem_s[0][l] <= b0_num[l][NUMB_W-1:QB_W];
				divb_q_s[0][l]   <= '0;
			end
			for (int k = 0; k < QB_W; k++) begin
				divb_neg_s[k+1] <= divb_neg_s[k];
				divb_big_s[k+1] <= divb_big_s[k];
				for (int l = 0; l < LANES; l++) begin
					divb_sat_s[k+1][l] <= divb_sat_s[k][l];
					divb_num_s[k+1][l] <= divb_num_s[k][l];
					divb_rem_s[k+1][l] <= divb_rem_nx[k+1][l];
					divb_q_s[k+1][l]   <= divb_q_nx[k+1][l];
				end
			end
			// output register
			out_data_q <= out_nx;
		end
	end

endmodule

// ----- hdl/mwsk_checker.sv -----
`timescale 1ns / 1ps

module mwsk_checker import mwsk_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_stall,
	input logic   out_valid,
	input logic   out_stall,
	input wheel_t out_data
);

	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// a stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("output payload changed while stalled");

	// input is held off only by a full, stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// a timed-out command drives all wheels to zero, unscaled
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.timed_out |->
			out_data.speed_front_left == '0 && out_data.speed_front_right == '0 &&
			out_data.speed_rear_left == '0 && out_data.speed_rear_right == '0 &&
			!out_data.scaled_down)
		else $error("timed-out result not zero");

endmodule

bind mecanum_wheel_speed_kinematics_core mwsk_checker u_mwsk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
